// File: design/lsrb_pkg.sv
// ----------------------------------------------------------------------------
// lsrb_pkg
// Shared types, codes and constants of the link-state tracker with
// reset-burst detection.
// ----------------------------------------------------------------------------
package lsrb_pkg;

  localparam int unsigned BurstCountDefault = 3;

  localparam int unsigned OpW     = 2;
  localparam int unsigned StateW  = 3;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned WindowW = 32;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [WindowW-1:0] WindowReset = 32'd10000000;
  localparam logic [AddrW-1:0]   AddrWindow  = 3'd0;

  localparam logic [OpW-1:0] OpForce   = 2'd0;
  localparam logic [OpW-1:0] OpReset   = 2'd1;
  localparam logic [OpW-1:0] OpSuccess = 2'd2;

  localparam logic [StateW-1:0] StDown       = 3'd0;
  localparam logic [StateW-1:0] StBooting    = 3'd1;
  localparam logic [StateW-1:0] StInit       = 3'd2;
  localparam logic [StateW-1:0] StUp         = 3'd3;
  localparam logic [StateW-1:0] StRecovering = 3'd4;
  localparam logic [StateW-1:0] StError      = 3'd5;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [StateW-1:0] link_state;
    logic              burst_seen;
    logic              state_changed;
  } result_t;

endpackage

// File: design/lsrb_cell.sv
// ----------------------------------------------------------------------------
// lsrb_cell
// One stage of the reset-time chain: holds one timestamp and takes its
// neighbor's on shift; zero marks an empty stage.
// ----------------------------------------------------------------------------
module lsrb_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsrb_pkg::cell_ctrl_t       ctrl_i,
  input  logic [lsrb_pkg::TimeW-1:0] time_i,
  output logic [lsrb_pkg::TimeW-1:0] time_o
);
  import lsrb_pkg::*;

  logic [TimeW-1:0] time_q;
  logic [TimeW-1:0] time_d;

  always_comb begin
    time_d = time_q;
    if (ctrl_i.clear) begin
      time_d = '0;
    end else if (ctrl_i.shift) begin
      time_d = time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else begin
      time_q <= time_d;
    end
  end

  assign time_o = time_q;

endmodule

// File: design/lsrb_out_buf.sv
// ----------------------------------------------------------------------------
// lsrb_out_buf
// Output register with a skid stage, so a new word is taken while the last
// result still waits.
// ----------------------------------------------------------------------------
module lsrb_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lsrb_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output lsrb_pkg::result_t data_o
);
  import lsrb_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign pop     = !out_valid_q || ready_i;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// File: design/link_state_with_reset_burst_detect.sv
// ----------------------------------------------------------------------------
// link_state_with_reset_burst_detect
// Link-state tracker that flags bursts of reset events within a time window.
// ----------------------------------------------------------------------------
// One event word is taken every cycle while the skid stage is empty; its
// result is registered for the output channel, through the skid stage when
// the receiver stalls, so input keeps flowing while one result waits.
// The state update, a 63-bit subtract and window compare, is combinational.
// Recent reset times travel down a chain of BURST_COUNT-1 cells, one step
// per recorded reset; the last cell holds the time that becomes the oldest
// of BURST_COUNT resets. A success in recovering or error clears the chain.
module link_state_with_reset_burst_detect #(
  parameter int unsigned BURST_COUNT = lsrb_pkg::BurstCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lsrb_pkg::OpW-1:0]     operation_i,
  input  logic [lsrb_pkg::StateW-1:0]  new_state_i,
  input  logic [lsrb_pkg::TimeW-1:0]   event_time_us_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lsrb_pkg::StateW-1:0]  link_state_o,
  output logic                         burst_seen_o,
  output logic                         state_changed_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsrb_pkg::AddrW-1:0]   paddr,
  input  logic [lsrb_pkg::DataW-1:0]   pwdata,
  output logic [lsrb_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import lsrb_pkg::*;

  localparam int unsigned Cells = BURST_COUNT - 1;

  logic [WindowW-1:0] window_q;
  logic [StateW-1:0]  mode_q;
  logic [StateW-1:0]  mode_d;
  logic               accept;
  logic               record;
  logic               clear;
  logic               burst;
  logic [TimeW-1:0]   oldest;
  logic [TimeW-1:0]   span;
  cell_ctrl_t         ctrl;
  result_t            result;
  logic [TimeW-1:0]   chain [Cells];

  assign pready = 1'b1;
  assign prdata = (paddr == AddrWindow) ? window_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (psel && penable && pwrite && (paddr == AddrWindow)) begin
      window_q <= pwdata;
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign oldest = chain[Cells-1];
  assign span   = event_time_us_i - oldest;

  always_comb begin
    mode_d = mode_q;
    record = 1'b0;
    clear  = 1'b0;
    burst  = 1'b0;
    case (operation_i)
      OpForce: begin
        if (new_state_i <= StError) begin
          mode_d = new_state_i;
        end
      end
      OpReset: begin
        if (mode_q inside {StDown, StBooting, StInit}) begin
          mode_d = StUp;
        end else begin
          record = 1'b1;
          burst  = (oldest != '0) && ((event_time_us_i < oldest) ||
                   (span <= {{(TimeW-WindowW){1'b0}}, window_q}));
          mode_d = burst ? StError : StRecovering;
        end
      end
      OpSuccess: begin
        if (mode_q inside {StRecovering, StError}) begin
          mode_d = StUp;
          clear  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= StDown;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  assign ctrl.shift = accept && record;
  assign ctrl.clear = accept && clear;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    lsrb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .time_i ((g == 0) ? event_time_us_i : chain[(g == 0) ? 0 : g-1]),
      .time_o (chain[g])
    );
  end

  assign result.link_state    = mode_d;
  assign result.burst_seen    = burst;
  assign result.state_changed = (mode_d != mode_q);

  result_t out_data;

  lsrb_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign link_state_o    = out_data.link_state;
  assign burst_seen_o    = out_data.burst_seen;
  assign state_changed_o = out_data.state_changed;

endmodule

// File: test/tb_link_state_with_reset_burst_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_state_with_reset_burst_detect
// Self-checking bench for the link-state tracker with reset-burst detection.
// ----------------------------------------------------------------------------
// A queue of event words feeds a clocked driver; each accepted word runs
// through a behavioral tracker that predicts state, burst and change flags.
// A clocked monitor pops the oldest prediction for every result word and
// compares it field by field. A directed opening covers the state paths,
// the ignored forces and operation, empty slots, time going backwards and
// the window edge; random phases follow under several window settings and
// idle patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_link_state_with_reset_burst_detect;
  import lsrb_pkg::*;

  localparam int unsigned BurstCount = BurstCountDefault;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseWords = 320;

  localparam logic [OpW-1:0]    OpUnused  = 2'd3;
  localparam logic [StateW-1:0] StBadLow  = 3'd6;
  localparam logic [StateW-1:0] StBadHigh = 3'd7;
  localparam logic [TimeW-1:0]  TimeMax   = {TimeW{1'b1}};

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [StateW-1:0] req;
    logic [TimeW-1:0]  stamp;
  } link_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OpW-1:0]     operation = '0;
  logic [StateW-1:0]  new_state = '0;
  logic [TimeW-1:0]   event_time_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StateW-1:0]  link_state;
  logic               burst_seen;
  logic               state_changed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  link_word_t pending_words[$];
  result_t    expected_results[$];
  link_word_t next_word;
  result_t    want;

  // tracker copy
  logic [StateW-1:0]  link_mode = StDown;
  logic [TimeW-1:0]   reset_log[BurstCount];
  int unsigned        log_ptr = 0;
  logic [WindowW-1:0] burst_window = WindowReset;

  logic [TimeW-1:0] stamp_us = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  link_state_with_reset_burst_detect i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .new_state_i    (new_state),
    .event_time_us_i(event_time_us),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .link_state_o   (link_state),
    .burst_seen_o   (burst_seen),
    .state_changed_o(state_changed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t track_link_event(input logic [OpW-1:0] op,
                                               input logic [StateW-1:0] req,
                                               input logic [TimeW-1:0] now);
    result_t           res;
    logic [StateW-1:0] prior;
    logic [TimeW-1:0]  oldest;
    logic              burst;
    prior = link_mode;
    burst = 1'b0;
    case (op)
      OpForce: begin
        if (req <= StError) link_mode = req;
      end
      OpReset: begin
        if (link_mode == StDown || link_mode == StBooting || link_mode == StInit) begin
          link_mode = StUp;
        end else begin
          reset_log[log_ptr] = now;
          log_ptr = (log_ptr + 1) % BurstCount;
          oldest = reset_log[log_ptr];
          if (oldest != '0 && (now < oldest || (now - oldest) <= burst_window)) burst = 1'b1;
          link_mode = burst ? StError : StRecovering;
        end
      end
      OpSuccess: begin
        if (link_mode == StRecovering || link_mode == StError) begin
          link_mode = StUp;
          for (int i = 0; i < BurstCount; i++) reset_log[i] = '0;
          log_ptr = 0;
        end
      end
      default: ;
    endcase
    res.link_state    = link_mode;
    res.burst_seen    = burst;
    res.state_changed = (link_mode != prior);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic queue_word(input logic [OpW-1:0] op, input logic [StateW-1:0] req,
                            input logic [TimeW-1:0] stamp);
    link_word_t w;
    w.op    = op;
    w.req   = req;
    w.stamp = stamp;
    pending_words.push_back(w);
  endtask

  task automatic queue_random_words(input int unsigned count);
    longint unsigned win;
    longint unsigned delta;
    int unsigned     pick;
    logic [OpW-1:0]  op;
    win = burst_window;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) op = OpReset;
      else if (pick < 15) op = OpSuccess;
      else if (pick < 19) op = OpForce;
      else op = OpUnused;
      delta = 0;
      case ($urandom_range(0, 9))
        0: delta = 0;
        1, 2, 3, 4: delta = longint'({$urandom}) % (win / 2 + 2);
        5, 6: delta = win - 1 + $urandom_range(0, 2);
        7: delta = win * 2 + $urandom;
        8: stamp_us = TimeW'({$urandom, $urandom});
        default: stamp_us = TimeW'($urandom_range(0, 3));
      endcase
      stamp_us = TimeW'(stamp_us + delta);
      queue_word(op, StateW'($urandom_range(0, 7)), stamp_us);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WindowW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWindow;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    burst_window = value;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(track_link_event(operation, new_state, event_time_us));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          operation     <= next_word.op;
          new_state     <= next_word.req;
          event_time_us <= next_word.stamp;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected word state %0d burst %0b changed %0b",
                                  link_state, burst_seen, state_changed));
        end else begin
          want = expected_results.pop_front();
          if (link_state !== want.link_state || burst_seen !== want.burst_seen ||
              state_changed !== want.state_changed)
            note_mismatch($sformatf("expected state %0d burst %0b changed %0b, got %0d %0b %0b",
                                    want.link_state, want.burst_seen, want.state_changed,
                                    link_state, burst_seen, state_changed));
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BurstCount; i++) reset_log[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_word(OpUnused, StUp, 63'd77);
    queue_word(OpForce, StBadLow, '0);
    queue_word(OpForce, StBadHigh, TimeMax);
    queue_word(OpReset, StDown, 63'd10);
    queue_word(OpForce, StBooting, '0);
    queue_word(OpReset, StDown, 63'd11);
    queue_word(OpForce, StInit, '0);
    queue_word(OpReset, StDown, 63'd12);
    queue_word(OpSuccess, StDown, 63'd13);
    queue_word(OpReset, StDown, '0);
    queue_word(OpReset, StDown, TimeMax);
    queue_word(OpReset, StDown, 63'd5);
    queue_word(OpReset, StDown, 63'd6);
    queue_word(OpUnused, StBadHigh, TimeMax);
    queue_word(OpSuccess, StDown, 63'd7);
    queue_word(OpForce, StRecovering, '0);
    queue_word(OpSuccess, StDown, '0);
    queue_word(OpForce, StError, '0);
    queue_word(OpReset, StDown, 63'd1000);
    queue_word(OpReset, StDown, 63'd2000);
    queue_word(OpReset, StDown, 63'd1000 + TimeW'(WindowReset));
    queue_word(OpReset, StDown, 63'd2001 + TimeW'(WindowReset));
    queue_word(OpForce, StDown, '0);
    queue_word(OpForce, StUp, '0);
    wait_drained();

    write_window('0);
    send_idle_pct = 31;
    recv_idle_pct = 67;
    queue_random_words(PhaseWords);
    wait_drained();

    write_window({WindowW{1'b1}});
    send_idle_pct = 67;
    recv_idle_pct = 31;
    queue_random_words(PhaseWords);
    wait_drained();

    write_window(WindowW'($urandom_range(1, 100000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    queue_random_words(PhaseWords);
    wait_drained();

    write_window(WindowW'($urandom));
    queue_random_words(PhaseWords);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
